/* hdl/mi4_pkg.sv */
`default_nettype none

package mi4_pkg;

   localparam int unsigned NUM_ELEMENTS = 16;
   localparam int unsigned INDEX_WIDTH = 4;
   localparam int unsigned FRAC_BITS = 32;
   localparam int unsigned NUM_PERMS = 6;
   localparam logic [2:0] LAST_PERM = 3'd5;

   // Column taken from each of the three minor rows for permutation p.
   function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] j);
      logic [5:0] row;
      begin
         case (p)
            3'd0: row = {2'd2, 2'd1, 2'd0};
            3'd1: row = {2'd0, 2'd2, 2'd1};
            3'd2: row = {2'd1, 2'd0, 2'd2};
            3'd3: row = {2'd1, 2'd2, 2'd0};
            3'd4: row = {2'd0, 2'd1, 2'd2};
            3'd5: row = {2'd2, 2'd0, 2'd1};
            default: row = {2'd2, 2'd1, 2'd0};
         endcase
         case (j)
            2'd0: perm_col = row[1:0];
            2'd1: perm_col = row[3:2];
            2'd2: perm_col = row[5:4];
            default: perm_col = row[1:0];
         endcase
      end
   endfunction

   // The last three permutations are odd.
   function automatic logic perm_odd(input logic [2:0] p);
      begin
         perm_odd = (p >= 3'd3);
      end
   endfunction

   // Store address of factor j of term p of the minor for cofactor k.
   // The minor drops row k[1:0] and column k[3:2] (transposed adjugate).
   function automatic logic [3:0] minor_addr(input logic [3:0] k, input logic [2:0] p,
                                             input logic [1:0] j);
      logic [1:0] skip_row;
      logic [1:0] skip_col;
      logic [1:0] pc;
      logic [1:0] row;
      logic [1:0] col;
      begin
         skip_row = k[1:0];
         skip_col = k[3:2];
         pc = perm_col(p, j);
         row = j + ((j >= skip_row) ? 2'd1 : 2'd0);
         col = pc + ((pc >= skip_col) ? 2'd1 : 2'd0);
         minor_addr = {row, col};
      end
   endfunction

endpackage

`default_nettype wire

/* hdl/matrix_inverse_4x4.sv */
`default_nettype none

// Channel  Dir  tdata (low bit up)                      tuser      tlast
// req      in   element_value[31:0]                     -          -
// rsp      out  result_value[31:0], result_index[35:32]  singular   last_of_run
//
// Sixteen requests load the matrix, one cycle each.
// The shared bit-serial multiplier forms 192 products for the 16 cofactors, with one
// more fetch per term; four products give the determinant, and the restoring divider
// then forms each quotient.
// The request side is not ready from the sixteenth element until the last
// result of the run is taken; a stalled result holds the sequencer.
// Reset is synchronous and clears the load count and the sequencer.
module matrix_inverse_4x4 #(
   parameter int unsigned ELEMENT_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // element_value[31:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // result_value[31:0], result_index[35:32], zeros
   output logic        rsp_tuser,   // singular
   output logic        rsp_tlast    // last_of_run
);

   localparam int unsigned W = ELEMENT_WIDTH;
   localparam int unsigned COFW = 3 * W + 2;
   localparam int unsigned DETW = 4 * W + 4;
   localparam int unsigned NW = COFW + mi4_pkg::FRAC_BITS;
   localparam int unsigned BCW = $clog2(W);
   localparam int unsigned DCW = $clog2(NW);
   localparam logic [BCW-1:0] BIT_LAST = BCW'(W - 1);
   localparam logic [DCW-1:0] DIV_LAST = DCW'(NW - 1);
   localparam logic [NW-1:0] LIM_POS = NW'((64'd1 << (W - 1)) - 64'd1);
   localparam logic [NW-1:0] LIM_NEG = NW'(64'd1 << (W - 1));

   typedef enum logic [3:0] {
      S_LOAD, S_FETCH, S_MUL, S_POST, S_COF, S_NEXT, S_CHECK, S_DIVINIT, S_DIV,
      S_DIVOUT, S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [3:0]        k_ff, k_in;
   logic [2:0]        p_ff, p_in;
   logic [1:0]        j_ff, j_in;
   logic              det_mode_ff, det_mode_in;
   logic [BCW-1:0]    bit_ff, bit_in;
   logic [DCW-1:0]    dcnt_ff, dcnt_in;
   logic [DETW-1:0]   mcand_ff, mcand_in;
   logic [W-1:0]      mbits_ff, mbits_in;
   logic [DETW-1:0]   prod_ff, prod_in;
   logic [DETW-1:0]   term_ff, term_in;
   logic [COFW-1:0]   acc_ff, acc_in;
   logic [DETW-1:0]   det_ff, det_in;
   logic [DETW-1:0]   den_ff, den_in;
   logic [DETW-1:0]   rem_ff, rem_in;
   logic [NW-1:0]     num_ff, num_in;
   logic              neg_ff, neg_in;
   logic              valid_ff, valid_in;
   logic [31:0]       val_ff, val_in;
   logic [3:0]        idx_ff, idx_in;
   logic              sing_ff, sing_in;
   logic              last_ff, last_in;

   logic [W-1:0]      store [mi4_pkg::NUM_ELEMENTS];
   logic [COFW-1:0]   cof_mem [mi4_pkg::NUM_ELEMENTS];

   logic              req_acc;
   logic              rsp_acc;
   logic [W-1:0]      elem;
   logic [COFW-1:0]   cof_rd;
   logic [COFW-1:0]   cof_abs;
   logic [DETW:0]     rem_sh;
   logic              ge;
   logic [NW-1:0]     q_sat;
   logic [W-1:0]      q_val;
   logic              sub_term;

   assign req_tready = (state_ff == S_LOAD);
   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = valid_ff && rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {4'd0, idx_ff, val_ff};
   assign rsp_tuser = sing_ff;
   assign rsp_tlast = last_ff;

   assign elem = store[mi4_pkg::minor_addr(k_ff, p_ff, j_ff)];
   assign cof_rd = cof_mem[k_ff];
   assign cof_abs = cof_rd[COFW-1] ? (~cof_rd + COFW'(1)) : cof_rd;
   assign rem_sh = {rem_ff, num_ff[NW-1]};
   assign ge = (rem_sh >= {1'b0, den_ff});
   assign sub_term = mi4_pkg::perm_odd(p_ff) ^ k_ff[2] ^ k_ff[0];

   always_comb begin
      logic [NW-1:0] lim;
      logic [NW-1:0] qs;
      lim = neg_ff ? LIM_NEG : LIM_POS;
      qs = (num_ff > lim) ? lim : num_ff;
      q_sat = neg_ff ? (~qs + NW'(1)) : qs;
      q_val = q_sat[W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      k_in = k_ff;
      p_in = p_ff;
      j_in = j_ff;
      det_mode_in = det_mode_ff;
      bit_in = bit_ff;
      dcnt_in = dcnt_ff;
      mcand_in = mcand_ff;
      mbits_in = mbits_ff;
      prod_in = prod_ff;
      term_in = term_ff;
      acc_in = acc_ff;
      det_in = det_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      neg_in = neg_ff;
      valid_in = valid_ff;
      val_in = val_ff;
      idx_in = idx_ff;
      sing_in = sing_ff;
      last_in = last_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  k_in = 4'd0;
                  p_in = 3'd0;
                  j_in = 2'd0;
                  acc_in = '0;
                  det_in = '0;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            if (j_ff == 2'd0) begin
               term_in = {{(DETW - W){elem[W-1]}}, elem};
               j_in = 2'd1;
            end else begin
               mcand_in = term_ff;
               mbits_in = elem;
               prod_in = '0;
               bit_in = '0;
               det_mode_in = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mbits_ff[0]) begin
               prod_in = (bit_ff == BIT_LAST) ? (prod_ff - mcand_ff) : (prod_ff + mcand_ff);
            end
            mcand_in = {mcand_ff[DETW-2:0], 1'b0};
            mbits_in = {1'b0, mbits_ff[W-1:1]};
            bit_in = bit_ff + BCW'(1);
            if (bit_ff == BIT_LAST) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (det_mode_ff) begin
               det_in = det_ff + prod_ff;
               state_in = S_NEXT;
            end else if (j_ff == 2'd2) begin
               acc_in = sub_term ? (acc_ff - prod_ff[COFW-1:0]) : (acc_ff + prod_ff[COFW-1:0]);
               j_in = 2'd0;
               if (p_ff == mi4_pkg::LAST_PERM) begin
                  state_in = S_COF;
               end else begin
                  p_in = p_ff + 3'd1;
                  state_in = S_FETCH;
               end
            end else begin
               term_in = prod_ff;
               j_in = j_ff + 2'd1;
               state_in = S_FETCH;
            end
         end
         S_COF: begin
            if (k_ff[1:0] == 2'd0) begin
               mcand_in = {{(DETW - COFW){acc_ff[COFW-1]}}, acc_ff};
               mbits_in = store[{2'd0, k_ff[3:2]}];
               prod_in = '0;
               bit_in = '0;
               det_mode_in = 1'b1;
               state_in = S_MUL;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            acc_in = '0;
            p_in = 3'd0;
            j_in = 2'd0;
            k_in = k_ff + 4'd1;
            state_in = (k_ff == 4'd15) ? S_CHECK : S_FETCH;
         end
         S_CHECK: begin
            den_in = det_ff[DETW-1] ? (~det_ff + DETW'(1)) : det_ff;
            k_in = 4'd0;
            if (det_ff == '0) begin
               valid_in = 1'b1;
               val_in = '0;
               idx_in = 4'd0;
               sing_in = 1'b1;
               last_in = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_DIVINIT;
            end
         end
         S_DIVINIT: begin
            num_in = {cof_abs, {mi4_pkg::FRAC_BITS{1'b0}}};
            neg_in = cof_rd[COFW-1] ^ det_ff[DETW-1];
            rem_in = '0;
            dcnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = ge ? DETW'(rem_sh - {1'b0, den_ff}) : rem_sh[DETW-1:0];
            num_in = {num_ff[NW-2:0], ge};
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DIV_LAST) begin
               state_in = S_DIVOUT;
            end
         end
         S_DIVOUT: begin
            valid_in = 1'b1;
            val_in = {{(32 - W){q_val[W-1]}}, q_val};
            idx_in = k_ff;
            sing_in = 1'b0;
            last_in = (k_ff == 4'd15);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_acc) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  state_in = S_LOAD;
               end else begin
                  k_in = k_ff + 4'd1;
                  state_in = S_DIVINIT;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff <= 4'd0;
         valid_ff <= 1'b0;
         k_ff <= 4'd0;
         p_ff <= 3'd0;
         j_ff <= 2'd0;
         det_mode_ff <= 1'b0;
         bit_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         valid_ff <= valid_in;
         k_ff <= k_in;
         p_ff <= p_in;
         j_ff <= j_in;
         det_mode_ff <= det_mode_in;
         bit_ff <= bit_in;
         dcnt_ff <= dcnt_in;
      end
      mcand_ff <= mcand_in;
      mbits_ff <= mbits_in;
      prod_ff <= prod_in;
      term_ff <= term_in;
      acc_ff <= acc_in;
      det_ff <= det_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      neg_ff <= neg_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      sing_ff <= sing_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         store[cnt_ff] <= req_tdata[W-1:0];
      end
      if (state_ff == S_COF) begin
         cof_mem[k_ff] <= acc_ff;
      end
   end

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> !rsp_tvalid)
      else $error("request accepted while a result is pending");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> (cnt_ff == 4'd0))
      else $error("load count not cleared during inversion");

   a_singular_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == '0))
      else $error("singular result malformed");

   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_tlast) |=> req_tready)
      else $error("loading not resumed after last result");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps

class inverse_scoreboard;
   logic signed [31:0] elements[16];
   int unsigned        load_pos;
   logic [37:0]        expected_q[$];
   int unsigned        mismatch_count;
   int unsigned        inversion_count;
   int unsigned        singular_count;
   int unsigned        saturated_count;

   function new();
      load_pos = 0;
      mismatch_count = 0;
      inversion_count = 0;
      singular_count = 0;
      saturated_count = 0;
   endfunction

   function logic signed [191:0] minor3(int skip_row, int skip_col);
      int rows[3];
      int cols[3];
      int n;
      int m;
      logic signed [191:0] acc;
      logic signed [191:0] term;
      acc = 0;
      n = 0;
      m = 0;
      for (int k = 0; k < 4; k++) begin
         if (k != skip_row) begin
            rows[n] = k;
            n++;
         end
         if (k != skip_col) begin
            cols[m] = k;
            m++;
         end
      end
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            if (b != a) begin
               term = 192'(elements[rows[0] * 4 + cols[a]]);
               term = term * 192'(elements[rows[1] * 4 + cols[b]]);
               term = term * 192'(elements[rows[2] * 4 + cols[3 - a - b]]);
               if (((b - a + 3) % 3) == 1) acc = acc + term;
               else acc = acc - term;
            end
         end
      end
      return acc;
   endfunction

   function logic [31:0] scaled_quotient(logic signed [191:0] cof,
                                         logic signed [191:0] det);
      logic               neg;
      logic [191:0]       num;
      logic [191:0]       den;
      logic [191:0]       quot;
      logic [63:0]        lim;
      neg = cof[191] ^ det[191];
      num = cof[191] ? -cof : cof;
      den = det[191] ? -det : det;
      num = num << 32;
      quot = num / den;
      lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
      if (quot > 192'(lim)) begin
         quot = 192'(lim);
         saturated_count++;
      end
      return neg ? -quot[31:0] : quot[31:0];
   endfunction

   function void note_element(logic [31:0] value);
      logic signed [191:0] cof[16];
      logic signed [191:0] det;
      elements[load_pos] = value;
      if (load_pos != 15) begin
         load_pos++;
         return;
      end
      load_pos = 0;
      inversion_count++;
      for (int k = 0; k < 16; k++) begin
         cof[k] = minor3(k % 4, k / 4);
         if (((k / 4 + k % 4) % 2) == 1) cof[k] = -cof[k];
      end
      det = 0;
      for (int k = 0; k < 4; k++) det = det + cof[k * 4] * 192'(elements[k]);
      if (det == 0) begin
         singular_count++;
         expected_q.push_back({1'b1, 1'b1, 4'd0, 32'd0});
      end else begin
         for (int k = 0; k < 16; k++)
            expected_q.push_back({k == 15, 1'b0, 4'(k), scaled_quotient(cof[k], det)});
      end
   endfunction

   function void check_result(logic [31:0] value, logic [3:0] index, logic sing,
                              logic last);
      logic [37:0] want;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result value %h index %0d singular %b last %b",
                  $time, value, index, sing, last);
         mismatch_count++;
         return;
      end
      want = expected_q.pop_front();
      if (want[31:0] !== value) begin
         $display("%0t: value expected %h actual %h", $time, want[31:0], value);
         mismatch_count++;
      end
      if (want[35:32] !== index) begin
         $display("%0t: index expected %0d actual %0d", $time, want[35:32], index);
         mismatch_count++;
      end
      if (want[36] !== sing) begin
         $display("%0t: singular expected %b actual %b", $time, want[36], sing);
         mismatch_count++;
      end
      if (want[37] !== last) begin
         $display("%0t: last expected %b actual %b", $time, want[37], last);
         mismatch_count++;
      end
   endfunction
endclass

module tb_top;
   localparam int unsigned IDLE_LIMIT = 200000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   inverse_scoreboard board;
   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   int unsigned       quiet_cycles;
   int unsigned       element_count;

   matrix_inverse_4x4 DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.note_element(req_tdata);
            element_count++;
         end
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata[31:0], rsp_tdata[35:32], rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_element(logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_element(int unsigned style);
      case (style)
         0: return $urandom();
         1: return 32'($signed($urandom_range(2 * 65536)) - 65536);
         2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return 32'($signed($urandom_range(512)) - 256);
      endcase
   endfunction

   task automatic send_matrix(logic [31:0] m[16]);
      for (int k = 0; k < 16; k++) send_element(m[k]);
   endtask

   task automatic send_random_matrix();
      logic [31:0] m[16];
      int unsigned style;
      style = $urandom_range(3);
      for (int k = 0; k < 16; k++) m[k] = random_element(style);
      if ($urandom_range(5) == 0) begin
         for (int c = 0; c < 4; c++) m[12 + c] = m[$urandom_range(1) * 4 + c];
      end
      send_matrix(m);
   endtask

   initial begin
      logic [31:0] m[16];
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 32'd0;
      rsp_tready = 1'b0;
      quiet_cycles = 0;
      element_count = 0;
      send_idle_pct = 15;
      recv_idle_pct = 69;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h0001_0000 : 32'd0;
      send_matrix(m);
      for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h0000_0001 : 32'd0;
      send_matrix(m);
      for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h8000_0000 : 32'hffff_ffff;
      send_matrix(m);
      for (int k = 0; k < 16; k++) m[k] = 32'h7fff_ffff;
      send_matrix(m);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 69 : 0;
         recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 15 : 0;
         repeat ((phase == 2) ? 3 : 2) send_random_matrix();
      end
      req_tvalid <= 1'b0;

      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d elements in %0d inversions, %0d singular, %0d saturated quotients.",
               element_count, board.inversion_count, board.singular_count,
               board.saturated_count);
      if (board.mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
